### rtl/core/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg
// Shared types, codes and helpers for the S-record text encoder: the
// configuration set, the record command that runs from front to back, and
// the hex and checksum helpers.
// ----------------------------------------------------------------------------
package srec_pkg;

  // Default for the longest record body, in bytes.
  localparam int MaxLineBytesDef = 252;
  // Entries in the command queue between the front and the back.
  localparam int QueueDepthDef   = 4;

  // Item kinds on the input channel.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_ADDRESS_MODE  = 3'd0;
  localparam logic [2:0] REG_LINE_LEN      = 3'd1;
  localparam logic [2:0] REG_BASE_ADDR     = 3'd2;
  localparam logic [2:0] REG_DATA_LENGTH   = 3'd3;
  localparam logic [2:0] REG_HEADER_LENGTH = 3'd4;

  // Address modes.
  localparam logic [1:0] MODE_ADDR16 = 2'd0;
  localparam logic [1:0] MODE_ADDR24 = 2'd1;

  // Record types that are fixed.
  localparam logic [3:0] TYPE_HEADER = 4'd0;
  localparam logic [3:0] TYPE_COUNT  = 4'd5;

  // Characters.
  localparam logic [6:0] CHAR_S    = 7'h53;
  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_NL   = 7'h0A;
  localparam logic [6:0] CHAR_NULL = 7'h00;

  // Phase of the run.
  typedef enum logic [1:0] {
    PH_HEADER,
    PH_DATA,
    PH_DONE
  } phase_e;

  // Steps of the character sequencer.
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_S,
    BK_TYPE,
    BK_CNT_HI,
    BK_CNT_LO,
    BK_ADDR,
    BK_DATA_HI,
    BK_DATA_LO,
    BK_SUM_HI,
    BK_SUM_LO,
    BK_NL,
    BK_DROP
  } back_st_e;

  // Configuration register set.
  typedef struct packed {
    logic [1:0]  address_mode;
    logic [7:0]  line_len;
    logic [31:0] base_addr;
    logic [31:0] data_length;
    logic [7:0]  header_length;
  } cfg_t;

  // One command for the back: a dropped item, or a piece of one record.
  typedef struct packed {
    logic        drop;      // Emit a single null character flagged as dropped.
    logic        open;      // Emit 'S', type, count and address first.
    logic        has_data;  // Emit one data byte.
    logic        close;     // Emit checksum and newline at the end.
    logic        last;      // The final character closes the item's run.
    logic [3:0]  rtype;
    logic [7:0]  count;
    logic [2:0]  abytes;
    logic [31:0] addr;
    logic [7:0]  data;
    logic [7:0]  csum;
  } cmd_t;

  // Uppercase hex digit of a nibble.
  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] c;
    if (n < 4'd10) begin
      c = 7'h30 + {3'b000, n};
    end else begin
      c = 7'h37 + {3'b000, n};
    end
    return c;
  endfunction

  // Address bytes for an address mode; mode three counts as 32-bit.
  function automatic logic [2:0] addr_len(input logic [1:0] mode);
    logic [2:0] ab;
    case (mode)
      MODE_ADDR16: ab = 3'd2;
      MODE_ADDR24: ab = 3'd3;
      default:     ab = 3'd4;
    endcase
    return ab;
  endfunction

  // Modulo-256 sum of the low address bytes that a record carries.
  function automatic logic [7:0] addr_sum(input logic [31:0] addr, input logic [2:0] ab);
    logic [7:0] s;
    s = addr[7:0] + addr[15:8];
    if (ab >= 3'd3) begin
      s = s + addr[23:16];
    end
    if (ab >= 3'd4) begin
      s = s + addr[31:24];
    end
    return s;
  endfunction

  // First sequencer step for a command.
  function automatic back_st_e first_step(input cmd_t c);
    back_st_e s;
    if (c.drop) begin
      s = BK_DROP;
    end else if (c.open) begin
      s = BK_S;
    end else begin
      s = BK_DATA_HI;
    end
    return s;
  endfunction

endpackage

### rtl/core/srecord_text_encoder.sv
// ----------------------------------------------------------------------------
// srecord_text_encoder
// S-record text encoder: header bytes, data bytes and a finish item in,
// record text out as one ASCII character per result.
// ----------------------------------------------------------------------------
// Path: an item's command is written into the command queue, the idle
// character sequencer loads it, and its characters pass an output register.
// Throughput: one character per cycle while the receiver is ready, set by
// the sequencer; a data byte gives its hex digits, one opening a record also
// its head, a closing one checksum and newline, and finish its records.
// Reset: asynchronous and active low; clears the run state, the queue and
// the output, and returns the registers to their reset values.
module srecord_text_encoder #(
  parameter int MAX_LINE_BYTES = srec_pkg::MaxLineBytesDef,
  parameter int QUEUE_DEPTH    = srec_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  char_code_o,
  output logic        last_of_run_o,
  output logic        dropped_o
);

  srec_pkg::cfg_t cfg;
  logic           push;
  srec_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  srec_pkg::cmd_t q_head;

  // Configuration registers.
  srec_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Item front end.
  srec_front #(
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .q_full_i   (q_full)
  );

  // Command queue.
  srec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  // Character back end.
  srec_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (q_head),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_code_o   (char_code_o),
    .last_of_run_o (last_of_run_o),
    .dropped_o     (dropped_o)
  );

endmodule

### rtl/core/srec_cfg.sv
// ----------------------------------------------------------------------------
// srec_cfg
// Configuration register block with an APB-style slave port. Writes land
// in the access phase; reads return the register value.
// ----------------------------------------------------------------------------
module srec_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output srec_pkg::cfg_t       cfg_o
);

  srec_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        srec_pkg::REG_ADDRESS_MODE:  cfg_d.address_mode  = pwdata[1:0];
        srec_pkg::REG_LINE_LEN:      cfg_d.line_len      = pwdata[7:0];
        srec_pkg::REG_BASE_ADDR:     cfg_d.base_addr     = pwdata;
        srec_pkg::REG_DATA_LENGTH:   cfg_d.data_length   = pwdata;
        srec_pkg::REG_HEADER_LENGTH: cfg_d.header_length = pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read mux.
  always_comb begin
    case (reg_idx)
      srec_pkg::REG_ADDRESS_MODE:  prdata = {30'd0, cfg_q.address_mode};
      srec_pkg::REG_LINE_LEN:      prdata = {24'd0, cfg_q.line_len};
      srec_pkg::REG_BASE_ADDR:     prdata = cfg_q.base_addr;
      srec_pkg::REG_DATA_LENGTH:   prdata = cfg_q.data_length;
      srec_pkg::REG_HEADER_LENGTH: prdata = {24'd0, cfg_q.header_length};
      default:                     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.address_mode  <= 2'd0;
      cfg_q.line_len      <= 8'd16;
      cfg_q.base_addr     <= 32'd0;
      cfg_q.data_length   <= 32'd0;
      cfg_q.header_length <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/srec_front.sv
// ----------------------------------------------------------------------------
// srec_front
// Front end: accepts items, checks their order, keeps the record state and
// turns each item into one or two record commands with the checksum
// already worked out.
// ----------------------------------------------------------------------------
module srec_front #(
  parameter int MAX_LINE_BYTES = srec_pkg::MaxLineBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  srec_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     kind_i,
  input  logic [7:0]     value_i,
  output logic           push_o,
  output srec_pkg::cmd_t push_cmd_o,
  input  logic           q_full_i
);

  localparam logic [7:0] MaxLen = 8'(MAX_LINE_BYTES);

  srec_pkg::phase_e phase_q, phase_d;
  logic             hdr_started_q, hdr_started_d;
  logic [7:0]       line_left_q, line_left_d;
  logic [7:0]       line_sum_q, line_sum_d;
  logic [31:0]      next_addr_q, next_addr_d;
  logic [31:0]      bytes_left_q, bytes_left_d;
  logic [16:0]      records_q, records_d;
  logic             pend_q, pend_d;
  srec_pkg::cmd_t   pend_cmd_q, pend_cmd_d;

  logic             accept;
  srec_pkg::cmd_t   item_cmd;

  // Working values of the classification.
  logic             header_done;
  logic [2:0]       ab;
  logic [7:0]       hdr_len;
  logic [7:0]       bpl_len;
  logic [7:0]       lim_len;
  logic [7:0]       dat_len;
  logic             dat_first;
  logic             dat_ok;
  logic             fin_ok;
  logic [7:0]       eff_left;
  logic [31:0]      eff_bytes;
  logic [31:0]      eff_addr;
  logic [7:0]       base_sum;
  logic [7:0]       new_sum;
  logic [7:0]       new_left;
  logic [7:0]       end_count;
  logic [7:0]       s5_sum;

  assign in_ready_o = !pend_q && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Item classification and state update.
  always_comb begin
    phase_d       = phase_q;
    hdr_started_d = hdr_started_q;
    line_left_d   = line_left_q;
    line_sum_d    = line_sum_q;
    next_addr_d   = next_addr_q;
    bytes_left_d  = bytes_left_q;
    records_d     = records_q;
    pend_d        = pend_q;
    pend_cmd_d    = pend_cmd_q;

    header_done = hdr_started_q ? (line_left_q == 8'd0) : (cfg_i.header_length == 8'd0);
    ab          = srec_pkg::addr_len(cfg_i.address_mode);
    hdr_len     = (cfg_i.header_length > MaxLen) ? MaxLen : cfg_i.header_length;

    dat_first = (phase_q == srec_pkg::PH_HEADER) && header_done &&
                (cfg_i.data_length != 32'd0);
    dat_ok    = dat_first || ((phase_q == srec_pkg::PH_DATA) && (bytes_left_q != 32'd0));
    fin_ok    = ((phase_q == srec_pkg::PH_HEADER) && header_done &&
                 (cfg_i.data_length == 32'd0)) ||
                ((phase_q == srec_pkg::PH_DATA) && (bytes_left_q == 32'd0));

    eff_left  = dat_first ? 8'd0 : line_left_q;
    eff_bytes = dat_first ? cfg_i.data_length : bytes_left_q;
    eff_addr  = dat_first ? cfg_i.base_addr : next_addr_q;

    // Data record length: clamp, address-size limit, then data remaining.
    if (cfg_i.line_len == 8'd0) begin
      bpl_len = 8'd1;
    end else if (cfg_i.line_len > MaxLen) begin
      bpl_len = MaxLen;
    end else begin
      bpl_len = cfg_i.line_len;
    end
    lim_len = 8'd254 - {5'd0, ab};
    dat_len = (bpl_len > lim_len) ? lim_len : bpl_len;
    if (eff_bytes < {24'd0, dat_len}) begin
      dat_len = eff_bytes[7:0];
    end

    end_count = {5'd0, ab} + 8'd1;
    s5_sum    = 8'd3 + records_q[15:8] + records_q[7:0];

    base_sum = line_sum_q;
    new_sum  = line_sum_q;
    new_left = line_left_q;

    item_cmd        = '0;
    item_cmd.last   = 1'b1;
    item_cmd.data   = value_i;

    if (kind_i == srec_pkg::KIND_HEADER && phase_q == srec_pkg::PH_HEADER && !header_done) begin
      // Header byte, opening the S0 record on the first one.
      item_cmd.open     = !hdr_started_q;
      item_cmd.has_data = 1'b1;
      item_cmd.rtype    = srec_pkg::TYPE_HEADER;
      item_cmd.count    = hdr_len + 8'd3;
      item_cmd.abytes   = 3'd2;
      base_sum          = hdr_started_q ? line_sum_q : hdr_len + 8'd3;
      new_sum           = base_sum + value_i;
      new_left          = (hdr_started_q ? line_left_q : hdr_len) - 8'd1;
      item_cmd.close    = (new_left == 8'd0);
      item_cmd.csum     = ~new_sum;
      if (accept) begin
        hdr_started_d = 1'b1;
        line_left_d   = new_left;
        line_sum_d    = new_sum;
      end
    end else if (kind_i == srec_pkg::KIND_DATA && dat_ok) begin
      // Data byte, opening a data record when the line is empty.
      item_cmd.open     = (eff_left == 8'd0);
      item_cmd.has_data = 1'b1;
      item_cmd.rtype    = {1'b0, ab} - 4'd1;
      item_cmd.count    = dat_len + {5'd0, ab} + 8'd1;
      item_cmd.abytes   = ab;
      item_cmd.addr     = eff_addr;
      base_sum          = item_cmd.open ?
                          (item_cmd.count + srec_pkg::addr_sum(eff_addr, ab)) : line_sum_q;
      new_sum           = base_sum + value_i;
      new_left          = (item_cmd.open ? dat_len : eff_left) - 8'd1;
      item_cmd.close    = (new_left == 8'd0);
      item_cmd.csum     = ~new_sum;
      if (accept) begin
        phase_d      = srec_pkg::PH_DATA;
        line_left_d  = new_left;
        line_sum_d   = new_sum;
        next_addr_d  = eff_addr + 32'd1;
        bytes_left_d = eff_bytes - 32'd1;
        if (item_cmd.close && records_q != 17'h1FFFF) begin
          records_d = records_q + 17'd1;
        end
      end
    end else if (kind_i == srec_pkg::KIND_FINISH && fin_ok) begin
      // Finish: optional S5 count record, then the end record.
      if (!records_q[16]) begin
        item_cmd.open   = 1'b1;
        item_cmd.close  = 1'b1;
        item_cmd.last   = 1'b0;
        item_cmd.rtype  = srec_pkg::TYPE_COUNT;
        item_cmd.count  = 8'd3;
        item_cmd.abytes = 3'd2;
        item_cmd.addr   = {16'd0, records_q[15:0]};
        item_cmd.csum   = ~s5_sum;
      end else begin
        item_cmd.open   = 1'b1;
        item_cmd.close  = 1'b1;
        item_cmd.rtype  = 4'd11 - {1'b0, ab};
        item_cmd.count  = end_count;
        item_cmd.abytes = ab;
        item_cmd.addr   = cfg_i.base_addr;
        item_cmd.csum   = ~(end_count + srec_pkg::addr_sum(cfg_i.base_addr, ab));
      end
      if (accept) begin
        phase_d = srec_pkg::PH_DONE;
        if (!records_q[16]) begin
          pend_d                = 1'b1;
          pend_cmd_d            = '0;
          pend_cmd_d.open       = 1'b1;
          pend_cmd_d.close      = 1'b1;
          pend_cmd_d.last       = 1'b1;
          pend_cmd_d.rtype      = 4'd11 - {1'b0, ab};
          pend_cmd_d.count      = end_count;
          pend_cmd_d.abytes     = ab;
          pend_cmd_d.addr       = cfg_i.base_addr;
          pend_cmd_d.csum       = ~(end_count + srec_pkg::addr_sum(cfg_i.base_addr, ab));
        end
      end
    end else begin
      // Out-of-order item: one flagged null character, state untouched.
      item_cmd.drop = 1'b1;
    end

    // The held end record goes out as soon as the queue has room.
    if (pend_q && !q_full_i) begin
      pend_d = 1'b0;
    end
  end

  assign push_o     = accept || (pend_q && !q_full_i);
  assign push_cmd_o = pend_q ? pend_cmd_q : item_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= srec_pkg::PH_HEADER;
      hdr_started_q <= 1'b0;
      line_left_q   <= 8'd0;
      line_sum_q    <= 8'd0;
      next_addr_q   <= 32'd0;
      bytes_left_q  <= 32'd0;
      records_q     <= 17'd0;
      pend_q        <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      hdr_started_q <= hdr_started_d;
      line_left_q   <= line_left_d;
      line_sum_q    <= line_sum_d;
      next_addr_q   <= next_addr_d;
      bytes_left_q  <= bytes_left_d;
      records_q     <= records_d;
      pend_q        <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_cmd_q <= pend_cmd_d;
  end

endmodule

### rtl/core/srec_fifo.sv
// ----------------------------------------------------------------------------
// srec_fifo
// Short command queue between the front and the back, so that each side
// can stall without holding up the other.
// ----------------------------------------------------------------------------
module srec_fifo #(
  parameter int DEPTH = srec_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  srec_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output srec_pkg::cmd_t head_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  srec_pkg::cmd_t    mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### rtl/core/srec_back.sv
// ----------------------------------------------------------------------------
// srec_back
// Back end: steps through each record command one character at a time and
// presents the characters through an output register.
// ----------------------------------------------------------------------------
module srec_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  srec_pkg::cmd_t q_head_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [6:0]     char_code_o,
  output logic           last_of_run_o,
  output logic           dropped_o
);

  srec_pkg::back_st_e state_q, state_d, step_next;
  srec_pkg::cmd_t     cur_q, cur_d;
  logic [2:0]         nib_q, nib_d;
  logic               step_final;
  logic               adv;
  logic               emit;
  logic [6:0]         char_c;
  logic               out_valid_q, out_valid_d;
  logic [6:0]         char_q;
  logic               last_q;
  logic               drop_q;

  assign adv  = !out_valid_q || out_ready_i;
  assign emit = (state_q != srec_pkg::BK_IDLE) && adv;

  // Record sequence: the step after this one, and whether this one ends the command.
  always_comb begin
    step_next  = state_q;
    step_final = 1'b0;
    case (state_q)
      srec_pkg::BK_S:      step_next = srec_pkg::BK_TYPE;
      srec_pkg::BK_TYPE:   step_next = srec_pkg::BK_CNT_HI;
      srec_pkg::BK_CNT_HI: step_next = srec_pkg::BK_CNT_LO;
      srec_pkg::BK_CNT_LO: step_next = srec_pkg::BK_ADDR;
      srec_pkg::BK_ADDR: begin
        if (nib_q != 3'd0) begin
          step_next = srec_pkg::BK_ADDR;
        end else if (cur_q.has_data) begin
          step_next = srec_pkg::BK_DATA_HI;
        end else if (cur_q.close) begin
          step_next = srec_pkg::BK_SUM_HI;
        end else begin
          step_final = 1'b1;
        end
      end
      srec_pkg::BK_DATA_HI: step_next = srec_pkg::BK_DATA_LO;
      srec_pkg::BK_DATA_LO: begin
        if (cur_q.close) begin
          step_next = srec_pkg::BK_SUM_HI;
        end else begin
          step_final = 1'b1;
        end
      end
      srec_pkg::BK_SUM_HI: step_next  = srec_pkg::BK_SUM_LO;
      srec_pkg::BK_SUM_LO: step_next  = srec_pkg::BK_NL;
      srec_pkg::BK_NL:     step_final = 1'b1;
      srec_pkg::BK_DROP:   step_final = 1'b1;
      default:             step_next  = state_q;
    endcase
  end

  // Next state: advance on each emitted character, load the next command at the end.
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    nib_d   = nib_q;
    q_pop_o = 1'b0;
    if (state_q == srec_pkg::BK_IDLE) begin
      if (q_valid_i) begin
        q_pop_o = 1'b1;
        cur_d   = q_head_i;
        state_d = srec_pkg::first_step(q_head_i);
      end
    end else if (adv) begin
      if (step_final) begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_head_i;
          state_d = srec_pkg::first_step(q_head_i);
        end else begin
          state_d = srec_pkg::BK_IDLE;
        end
      end else begin
        state_d = step_next;
      end
      if (state_q == srec_pkg::BK_CNT_LO) begin
        nib_d = 3'(({1'b0, cur_q.abytes} << 1) - 4'd1);
      end else if (state_q == srec_pkg::BK_ADDR) begin
        nib_d = nib_q - 3'd1;
      end
    end
  end

  // Character of the current step.
  always_comb begin
    case (state_q)
      srec_pkg::BK_S:       char_c = srec_pkg::CHAR_S;
      srec_pkg::BK_TYPE:    char_c = srec_pkg::CHAR_ZERO + {3'd0, cur_q.rtype};
      srec_pkg::BK_CNT_HI:  char_c = srec_pkg::hex_char(cur_q.count[7:4]);
      srec_pkg::BK_CNT_LO:  char_c = srec_pkg::hex_char(cur_q.count[3:0]);
      srec_pkg::BK_ADDR:    char_c = srec_pkg::hex_char(cur_q.addr[{nib_q, 2'b00} +: 4]);
      srec_pkg::BK_DATA_HI: char_c = srec_pkg::hex_char(cur_q.data[7:4]);
      srec_pkg::BK_DATA_LO: char_c = srec_pkg::hex_char(cur_q.data[3:0]);
      srec_pkg::BK_SUM_HI:  char_c = srec_pkg::hex_char(cur_q.csum[7:4]);
      srec_pkg::BK_SUM_LO:  char_c = srec_pkg::hex_char(cur_q.csum[3:0]);
      srec_pkg::BK_NL:      char_c = srec_pkg::CHAR_NL;
      default:              char_c = srec_pkg::CHAR_NULL;
    endcase
  end

  // Output register valid.
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srec_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nib_q <= nib_d;
    if (emit) begin
      char_q <= char_c;
      last_q <= step_final && cur_q.last;
      drop_q <= (state_q == srec_pkg::BK_DROP);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign char_code_o   = char_q;
  assign last_of_run_o = last_q;
  assign dropped_o     = drop_q;

  // A dropped item shows a null character and closes its run.
  a_drop_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && drop_q) |-> (char_q == srec_pkg::CHAR_NULL && last_q))
    else $error("dropped item with a non-null character or open run");

  // The address nibble counter stays inside the record's address.
  a_nib_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == srec_pkg::BK_ADDR) |-> ({1'b0, nib_q} < ({1'b0, cur_q.abytes} << 1)))
    else $error("address nibble counter beyond the address width");

  // Commands are taken from the queue only when it holds one.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> q_valid_i)
    else $error("command popped from an empty queue");

endmodule

### verif/tb_srecord_text_encoder.sv
// ----------------------------------------------------------------------------
// tb_srecord_text_encoder
// Self-checking bench for the S-record text encoder. A queue of pending
// items feeds a bursty driver, a stalling receiver takes the record text,
// and an encoder model in the bench predicts every character, which the
// monitor checks field by field. One run goes from header through data to
// finish, with out-of-order items mixed in and settings changed in between.
// ----------------------------------------------------------------------------
module tb_srecord_text_encoder;
  import srec_pkg::*;

  localparam int          ClkHalf         = 5;
  localparam int          ResetCycles     = 7;
  localparam int          LimitTime       = 5_000_000;
  localparam int          TailCycles      = 40;
  localparam int          LongHold        = 400;
  localparam int unsigned HeaderLen       = 6;
  localparam int unsigned LongRecord      = 40;
  localparam int unsigned MaxLine         = MaxLineBytesDef;
  localparam int unsigned RecordByteLimit = 254;
  localparam int unsigned EndTypeSum      = 11;
  localparam logic [16:0] CountLimit      = 17'h0FFFF;
  localparam logic [16:0] RecordsSat      = 17'h1FFFF;
  localparam logic [1:0]  KIND_UNUSED     = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_of_run;
    logic       dropped;
  } char_t;

  // Clock, reset and every block input start at known values.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  kind_i      = KIND_HEADER;
  logic [7:0]  value_i     = '0;
  logic        out_ready_i = 1'b0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [6:0]  char_code_o;
  logic        last_of_run_o;
  logic        dropped_o;

  item_t      items_to_send[$];
  char_t      expected_chars[$];
  logic [6:0] run_chars[$];

  // Encoder model state and its copy of the registers.
  cfg_t        cfg_m;
  phase_e      ph_m;
  logic [7:0]  hdr_idx_m;
  logic [7:0]  line_left_m;
  logic [7:0]  line_sum_m;
  logic [31:0] next_addr_m;
  logic [31:0] bytes_left_m;
  logic [16:0] records_m;

  bit item_taken     = 1'b0;
  int burst_left     = 1;
  int gap_left       = 0;
  int hold_asks      = 0;
  int holds_served   = 0;
  int hold_left      = 0;
  int stall_mode     = 0;
  int window_left    = 0;
  int stall_tick     = 0;
  int mismatch_count = 0;

  srecord_text_encoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_code_o   (char_code_o),
    .last_of_run_o (last_of_run_o),
    .dropped_o     (dropped_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Encoder model
  // ---------------------------------------------------------------------------

  function automatic logic [6:0] nibble_char(input logic [3:0] n);
    logic [6:0] c;
    if (n < 4'd10) begin
      c = CHAR_ZERO + {3'b000, n};
    end else begin
      c = 7'h41 + ({3'b000, n} - 7'd10);
    end
    return c;
  endfunction

  function automatic int unsigned addr_width_bytes(input logic [1:0] mode);
    int unsigned n;
    case (mode)
      MODE_ADDR16: n = 2;
      MODE_ADDR24: n = 3;
      default:     n = 4;
    endcase
    return n;
  endfunction

  function automatic void put_hex(input logic [7:0] b);
    run_chars.push_back(nibble_char(b[7:4]));
    run_chars.push_back(nibble_char(b[3:0]));
  endfunction

  // 'S', type digit, byte count and the big-endian address; seeds the sum.
  function automatic void rec_open(input logic [3:0] rtype, input int unsigned ab,
                                   input logic [7:0] payload, input logic [31:0] addr);
    logic [7:0] count;
    logic [7:0] b;
    int unsigned i;
    count = 8'(ab) + payload + 8'd1;
    run_chars.push_back(CHAR_S);
    run_chars.push_back(CHAR_ZERO + {3'b000, rtype});
    put_hex(count);
    line_sum_m = count;
    for (i = ab; i > 0; i--) begin
      b = 8'(addr >> (8 * (i - 1)));
      put_hex(b);
      line_sum_m = line_sum_m + b;
    end
  endfunction

  function automatic void rec_close();
    put_hex(~line_sum_m);
    run_chars.push_back(CHAR_NL);
  endfunction

  function automatic void add_body_byte(input logic [7:0] b);
    put_hex(b);
    line_sum_m  = line_sum_m + b;
    line_left_m = line_left_m - 8'd1;
  endfunction

  function automatic void reset_model();
    cfg_m.address_mode  = MODE_ADDR16;
    cfg_m.line_len      = 8'd16;
    cfg_m.base_addr     = '0;
    cfg_m.data_length   = '0;
    cfg_m.header_length = '0;
    ph_m         = PH_HEADER;
    hdr_idx_m    = '0;
    line_left_m  = '0;
    line_sum_m   = '0;
    next_addr_m  = '0;
    bytes_left_m = '0;
    records_m    = '0;
  endfunction

  function automatic void write_model_reg(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      REG_ADDRESS_MODE:  cfg_m.address_mode  = val[1:0];
      REG_LINE_LEN:      cfg_m.line_len      = val[7:0];
      REG_BASE_ADDR:     cfg_m.base_addr     = val;
      REG_DATA_LENGTH:   cfg_m.data_length   = val;
      REG_HEADER_LENGTH: cfg_m.header_length = val[7:0];
      default: begin
      end
    endcase
  endfunction

  // Works out the characters that one accepted item causes.
  function automatic void encode_item(input logic [1:0] kind, input logic [7:0] value);
    logic        header_done;
    logic        accepted;
    int unsigned ab;
    int unsigned len;
    char_t       entry;
    header_done = (hdr_idx_m == 8'd0) ? (cfg_m.header_length == 8'd0)
                                      : (line_left_m == 8'd0);
    accepted = 1'b0;
    run_chars.delete();
    case (kind)
      KIND_HEADER: begin
        if (ph_m == PH_HEADER && !header_done) begin
          accepted = 1'b1;
          // The header length is fixed by the first header byte.
          if (hdr_idx_m == 8'd0) begin
            len = cfg_m.header_length;
            if (len > MaxLine) len = MaxLine;
            rec_open(TYPE_HEADER, 2, 8'(len), 32'd0);
            line_left_m = 8'(len);
          end
          add_body_byte(value);
          if (hdr_idx_m != 8'hFF) hdr_idx_m = hdr_idx_m + 8'd1;
          if (line_left_m == 8'd0) rec_close();
        end
      end
      KIND_DATA: begin
        // The first data byte loads the start address and the length.
        if (ph_m == PH_HEADER && header_done && cfg_m.data_length != 32'd0) begin
          next_addr_m  = cfg_m.base_addr;
          bytes_left_m = cfg_m.data_length;
          line_left_m  = '0;
          ph_m         = PH_DATA;
          accepted     = 1'b1;
        end else if (ph_m == PH_DATA && bytes_left_m != 32'd0) begin
          accepted = 1'b1;
        end
        if (accepted) begin
          if (line_left_m == 8'd0) begin
            ab  = addr_width_bytes(cfg_m.address_mode);
            len = cfg_m.line_len;
            if (len < 1) len = 1;
            if (len > MaxLine) len = MaxLine;
            if (len > RecordByteLimit - ab) len = RecordByteLimit - ab;
            if (len > bytes_left_m) len = bytes_left_m;
            rec_open(4'(ab - 1), ab, 8'(len), next_addr_m);
            line_left_m = 8'(len);
          end
          add_body_byte(value);
          bytes_left_m = bytes_left_m - 32'd1;
          next_addr_m  = next_addr_m + 32'd1;
          if (line_left_m == 8'd0) begin
            rec_close();
            if (records_m != RecordsSat) records_m = records_m + 17'd1;
          end
        end
      end
      KIND_FINISH: begin
        if ((ph_m == PH_HEADER && header_done && cfg_m.data_length == 32'd0) ||
            (ph_m == PH_DATA && bytes_left_m == 32'd0)) begin
          accepted = 1'b1;
          ab = addr_width_bytes(cfg_m.address_mode);
          // The count record is left out once the count no longer fits.
          if (records_m <= CountLimit) begin
            rec_open(TYPE_COUNT, 2, 8'd0, {15'd0, records_m});
            rec_close();
          end
          rec_open(4'(EndTypeSum - ab), ab, 8'd0, cfg_m.base_addr);
          rec_close();
          ph_m = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    if (!accepted) begin
      entry.char_code   = CHAR_NULL;
      entry.last_of_run = 1'b1;
      entry.dropped     = 1'b1;
      expected_chars.push_back(entry);
    end else begin
      foreach (run_chars[i]) begin
        entry.char_code   = run_chars[i];
        entry.last_of_run = (i == run_chars.size() - 1);
        entry.dropped     = 1'b0;
        expected_chars.push_back(entry);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: bursts of items with random gaps
  // ---------------------------------------------------------------------------

  // An item is taken at the edge where valid and ready are both high.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      encode_item(kind_i, value_i);
      item_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    item_t next_item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !item_taken) begin
      // Hold the offered item until it is taken.
    end else begin
      item_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        next_item = items_to_send.pop_front();
        in_valid_i <= 1'b1;
        kind_i     <= next_item.kind;
        value_i    <= next_item.value;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = $urandom_range(0, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall pattern in windows, and a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    stall_tick++;
    if (hold_asks != holds_served) begin
      holds_served = hold_asks;
      hold_left    = LongHold;
    end
    if (window_left == 0) begin
      stall_mode  = $urandom_range(0, 3);
      window_left = $urandom_range(20, 80);
    end else begin
      window_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= (stall_tick % 3 == 0);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Each character taken is checked against the oldest expectation.
  always @(posedge clk_i) begin
    char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected character: code %h last %b dropped %b",
                   char_code_o, last_of_run_o, dropped_o);
        end
      end else begin
        want = expected_chars.pop_front();
        if (char_code_o !== want.char_code || last_of_run_o !== want.last_of_run ||
            dropped_o !== want.dropped) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected code %h last %b dropped %b, got %h %b %b",
                     want.char_code, want.last_of_run, want.dropped,
                     char_code_o, last_of_run_o, dropped_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    write_model_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic push_item(input logic [1:0] kind, input logic [7:0] value);
    item_t it;
    it.kind  = kind;
    it.value = value;
    items_to_send.push_back(it);
  endtask

  // An out-of-order item of any kind other than the one the run expects.
  task automatic push_noise(input logic [1:0] good_kind);
    logic [1:0] k;
    k = 2'($urandom_range(0, 3));
    if (k == good_kind) k = KIND_UNUSED;
    push_item(k, 8'($urandom_range(0, 255)));
  endtask

  // Waits until every item has been taken and every character checked.
  task automatic wait_idle();
    @(posedge clk_i);
    while (items_to_send.size() != 0 || in_valid_i || expected_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    int unsigned rand_total;
    int unsigned data_total;
    int unsigned sent;
    int unsigned seg;
    int unsigned seg_len;
    int unsigned k;
    logic [7:0]  bpl;
    logic [1:0]  mode;

    reset_model();
    rand_total = $urandom_range(35, 45);
    data_total = 3 + LongRecord + rand_total;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Header byte with no header record, data byte with no data, unused kind.
    push_item(KIND_HEADER, 8'h00);
    push_item(KIND_DATA, 8'hFF);
    push_item(KIND_UNUSED, 8'hFF);
    wait_idle();

    // A short header, shortest lines (clamped up), start just below the wrap.
    reg_write(REG_HEADER_LENGTH, 32'(HeaderLen));
    reg_write(REG_ADDRESS_MODE, 32'(MODE_ADDR16));
    reg_write(REG_LINE_LEN, 32'd0);
    reg_write(REG_BASE_ADDR, 32'hFFFF_FFFC);

    // Data and finish before the header is complete, then the first header bytes.
    push_item(KIND_DATA, 8'h11);
    push_item(KIND_FINISH, 8'h00);
    push_item(KIND_HEADER, 8'h00);
    push_item(KIND_HEADER, 8'hFF);
    push_item(KIND_HEADER, 8'hA5);
    wait_idle();

    // The header length is already fixed, so this write must not matter.
    reg_write(REG_HEADER_LENGTH, 32'd1);
    for (k = 0; k < HeaderLen - 3; k++) begin
      if ($urandom_range(0, 9) == 0) push_noise(KIND_HEADER);
      push_item(KIND_HEADER, 8'($urandom_range(0, 255)));
    end
    // One header byte too many.
    push_item(KIND_HEADER, 8'h3C);
    wait_idle();

    // One-byte data records across the low address bytes.
    reg_write(REG_DATA_LENGTH, data_total);
    push_item(KIND_DATA, 8'h00);
    push_item(KIND_DATA, 8'hFF);
    push_item(KIND_DATA, 8'h5A);
    wait_idle();

    // Registers that are already loaded only change the end record address.
    reg_write(REG_BASE_ADDR, 32'd0);
    reg_write(REG_DATA_LENGTH, 32'hFFFF_FFFF);

    // One long record in mode three, taken as 32-bit, under a long receiver hold.
    reg_write(REG_LINE_LEN, 32'(LongRecord));
    reg_write(REG_ADDRESS_MODE, 32'd3);
    hold_asks++;
    for (k = 0; k < LongRecord; k++) begin
      if ($urandom_range(0, 9) == 0) push_noise(KIND_DATA);
      push_item(KIND_DATA, 8'($urandom_range(0, 255)));
    end

    // Random segments of data under changing settings.
    sent = 0;
    seg  = 0;
    while (sent < rand_total) begin
      wait_idle();
      case (seg)
        0: bpl = 8'd1;
        1: bpl = 8'd252;
        2: bpl = 8'd0;
        default: begin
          case ($urandom_range(0, 9))
            0:       bpl = 8'd255;
            1:       bpl = 8'd252;
            2:       bpl = 8'd0;
            default: bpl = 8'($urandom_range(2, 20));
          endcase
        end
      endcase
      mode = (seg < 4) ? 2'(seg) : 2'($urandom_range(0, 3));
      reg_write(REG_ADDRESS_MODE, 32'(mode));
      reg_write(REG_LINE_LEN, 32'(bpl));
      if ($urandom_range(0, 1) == 1) reg_write(REG_BASE_ADDR, $urandom());
      if ($urandom_range(0, 3) == 0) begin
        reg_write(REG_HEADER_LENGTH, 32'($urandom_range(0, 255)));
      end
      seg_len = $urandom_range(5, 30);
      if (seg_len > rand_total - sent) seg_len = rand_total - sent;
      for (k = 0; k < seg_len; k++) begin
        if ($urandom_range(0, 9) == 0) push_noise(KIND_DATA);
        push_item(KIND_DATA, 8'($urandom_range(0, 255)));
      end
      sent += seg_len;
      seg++;
    end

    // One data byte too many.
    push_item(KIND_DATA, 8'hC3);
    wait_idle();

    // Finish with a 32-bit end record at the top address.
    reg_write(REG_ADDRESS_MODE, 32'd2);
    reg_write(REG_BASE_ADDR, 32'hFFFF_FFFF);
    push_item(KIND_FINISH, 8'hFF);
    // Everything after finish is dropped.
    push_item(KIND_HEADER, 8'($urandom_range(0, 255)));
    push_item(KIND_DATA, 8'($urandom_range(0, 255)));
    push_item(KIND_FINISH, 8'($urandom_range(0, 255)));
    push_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
    wait_idle();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LimitTime);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/core/srec_pkg.sv
rtl/core/srec_cfg.sv
rtl/core/srec_front.sv
rtl/core/srec_fifo.sv
rtl/core/srec_back.sv
rtl/core/srecord_text_encoder.sv
verif/tb_srecord_text_encoder.sv
